// ===== rtl/lzw_pkg.sv =====
// ----------------------------------------------------------------------------
// lzw_pkg
// Shared word types and fixed constants of the variable-width LZW encoder.
// ----------------------------------------------------------------------------
package lzw_pkg;

  // input word: one raw byte and its end-of-stream mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_word_t;

  // output word: one emitted code
  typedef struct packed {
    logic [11:0] code_value;
    logic [3:0]  code_bits;
    logic        run_last;
    logic        stream_done;
  } out_word_t;

  localparam int START_WIDTH = 9;
  localparam int FIRST_FREE  = 257;
  localparam int EPOCH_W     = 8;
  localparam logic [7:0] INIT_FLIP = 8'h80;

endpackage

// ===== rtl/lzw_ram.sv =====
// ----------------------------------------------------------------------------
// lzw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/lzw_byte_encoder.sv =====
// ----------------------------------------------------------------------------
// lzw_byte_encoder
// Variable-width LZW compressor: one byte per word in, up to two codes out.
// ----------------------------------------------------------------------------
// steps: a byte with no current match goes straight to finishing; a lookup byte
//   reads and probes hash ram slots in turn (one ram read each) until a hit or
//   an empty slot; each emitted code then waits while the output side stalls
// flow: one byte at a time; the next byte is taken only in idle, once the last
//   is through, and the probe loop over the hash ram sets the pace
// reset: synchronous; afterwards a clearing pass over all 2*DICT_SIZE slots sweeps
//   the hash ram before the first byte is taken; the same pass repeats after
//   every 255th dictionary clear, when the epoch mark wraps
module lzw_byte_encoder #(
  parameter int DICT_SIZE = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  lzw_pkg::in_word_t  src_word,
  output logic               dst_valid,
  input  logic               dst_stall,
  output lzw_pkg::out_word_t dst_word
);
  import lzw_pkg::*;

  localparam int CW = $clog2(DICT_SIZE);   // code index width
  localparam int NW = CW + 1;              // count and match, which can hold DICT_SIZE
  localparam int WW = $clog2(CW + 1);      // code width register
  localparam int HB = CW + 1;              // hash ram address width
  localparam int HD = 2 * DICT_SIZE;       // hash ram depth
  localparam int SW = EPOCH_W + 2 * CW + 8;

  localparam logic [NW-1:0]      NO_CODE   = NW'(DICT_SIZE);
  localparam logic [NW-1:0]      FULL      = NW'(DICT_SIZE);
  localparam logic [NW-1:0]      FREE0     = NW'(FIRST_FREE);
  localparam logic [WW-1:0]      W_START   = WW'(START_WIDTH);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam logic [HB-1:0]      HASH_LAST = HB'(HD - 1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_READ, S_PROBE, S_FIN, S_SEND_A, S_SEND_B, S_END
  } state_t;

  state_t             state;
  logic [NW-1:0]      entry_count;
  logic [NW-1:0]      match_code;
  logic [WW-1:0]      width_now;
  logic [EPOCH_W-1:0] epoch;
  logic               narrow_pend;   // dictionary was cleared, width drops after next byte
  logic [7:0]         cur_byte;
  logic               cur_eos;
  logic               has_a;         // a code waits from the lookup miss
  logic [NW-1:0]      a_code;
  logic [WW-1:0]      a_bits;
  logic [HB-1:0]      idx;           // probe address, also the clearing sweep address

  // hash ram port
  logic          ram_we;
  logic [HB-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic [SW-1:0] ram_rdata;

  // slot layout: epoch mark, code, prefix code, byte
  logic [EPOCH_W-1:0] rd_epoch;
  logic [CW-1:0]      rd_code;
  logic [CW-1:0]      rd_prefix;
  logic [7:0]         rd_byte;
  logic               slot_live;
  logic               slot_hit;
  logic [HB-1:0]      hash_idx;
  logic               out_free;

  assign rd_epoch  = ram_rdata[SW-1 -: EPOCH_W];
  assign rd_code   = ram_rdata[2*CW+7 -: CW];
  assign rd_prefix = ram_rdata[CW+7 -: CW];
  assign rd_byte   = ram_rdata[7:0];

  // a slot written under an older epoch counts as empty
  assign slot_live = (rd_epoch == epoch);
  assign slot_hit  = slot_live && (rd_prefix == match_code[CW-1:0])
                     && (rd_byte == cur_byte);

  // cheap fold of prefix and byte into the hash ram address
  assign hash_idx = {1'b0, match_code[CW-1:0]}
                    ^ {src_word.data_byte, (HB-8)'(0)};

  assign out_free  = !dst_valid || !dst_stall;
  assign src_stall = (state != S_IDLE);

  // the clearing sweep zeroes each slot; the miss writes the new entry into the empty slot it stopped on
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    if (state == S_CLR) begin
      ram_we = 1'b1;
    end else if (state == S_PROBE && !slot_live) begin
      ram_we    = 1'b1;
      ram_wdata = {epoch, entry_count[CW-1:0], match_code[CW-1:0], cur_byte};
    end
  end

  lzw_ram #(
    .WIDTH(SW),
    .DEPTH(HD)
  ) u_hash_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      idx         <= '0;
      entry_count <= FREE0;
      match_code  <= NO_CODE;
      width_now   <= W_START;
      epoch       <= '0;
      narrow_pend <= 1'b0;
      has_a       <= 1'b0;
      dst_valid   <= 1'b0;
    end else begin
      // the send states load the next word themselves when the slot frees
      if (dst_valid && !dst_stall && state != S_SEND_A && state != S_SEND_B) begin
        dst_valid <= 1'b0;
      end
      unique case (state)
        // sweep the hash ram, then start a fresh epoch
        S_CLR: begin
          idx <= idx + 1'b1;
          if (idx == HASH_LAST) begin
            epoch <= EPOCH_W'(1);
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (src_valid) begin
            cur_byte <= src_word.data_byte;
            cur_eos  <= src_word.end_of_stream;
            has_a    <= 1'b0;
            if (match_code == NO_CODE) begin
              match_code <= NW'(src_word.data_byte ^ INIT_FLIP);
              state      <= S_FIN;
            end else begin
              idx   <= hash_idx;
              state <= S_READ;
            end
          end
        end
        // ram read in flight
        S_READ: begin
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (!slot_live) begin
            // miss: new entry goes in, old match is emitted
            has_a       <= 1'b1;
            a_code      <= match_code;
            a_bits      <= width_now;
            match_code  <= NW'(cur_byte ^ INIT_FLIP);
            entry_count <= entry_count + 1'b1;
            if ((entry_count >> width_now) != '0) begin
              width_now <= width_now + 1'b1;
            end
            state <= S_FIN;
          end else if (slot_hit) begin
            match_code <= {1'b0, rd_code};
            state      <= S_FIN;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_READ;
          end
        end
        S_FIN: begin
          if (narrow_pend) begin
            width_now   <= W_START;
            narrow_pend <= 1'b0;
          end
          priority if (has_a) begin
            state <= S_SEND_A;
          end else if (cur_eos) begin
            state <= S_SEND_B;
          end else begin
            state <= S_END;
          end
        end
        S_SEND_A: begin
          if (out_free) begin
            dst_valid            <= 1'b1;
            dst_word.code_value  <= 12'(a_code);
            dst_word.code_bits   <= 4'(a_bits);
            dst_word.run_last    <= !cur_eos;
            dst_word.stream_done <= 1'b0;
            state                <= cur_eos ? S_SEND_B : S_END;
          end
        end
        // flush of the current match at end of stream
        S_SEND_B: begin
          if (out_free) begin
            dst_valid            <= 1'b1;
            dst_word.code_value  <= 12'(match_code);
            dst_word.code_bits   <= 4'(width_now);
            dst_word.run_last    <= 1'b1;
            dst_word.stream_done <= 1'b1;
            state                <= S_END;
          end
        end
        // stream end or full dictionary: drop all entries by moving the epoch, or by a sweep once it wraps
        S_END: begin
          if (cur_eos || entry_count == FULL) begin
            entry_count <= FREE0;
            if (cur_eos) begin
              match_code  <= NO_CODE;
              width_now   <= W_START;
              narrow_pend <= 1'b0;
            end else begin
              narrow_pend <= 1'b1;
            end
            if (epoch == EPOCH_MAX) begin
              idx   <= '0;
              state <= S_CLR;
            end else begin
              epoch <= epoch + 1'b1;
              state <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

  // dictionary fill stays between the initial entries and full
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count >= FREE0 && entry_count <= FULL)
    else $error("entry count out of range");

  // epoch zero marks swept slots and is never live outside the sweep
  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    state != S_CLR |-> epoch != '0)
    else $error("live epoch is zero");

  // an accepted byte goes to the lookup or straight to finishing
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    src_valid && !src_stall |=> state == S_READ || state == S_FIN)
    else $error("accepted byte went nowhere");

  // code width stays between the start width and the widest code
  a_width_range: assert property (@(posedge clk) disable iff (rst)
    width_now >= W_START && width_now <= WW'(CW))
    else $error("code width out of range");

endmodule
